### sv/grid_vertex_normal_estimator_unit_macros.svh
// Assertion macros shared by the grid vertex normal estimator
`ifndef GRID_VERTEX_NORMAL_ESTIMATOR_UNIT_MACROS_SVH
`define GRID_VERTEX_NORMAL_ESTIMATOR_UNIT_MACROS_SVH

// Same-cycle implication, clocked on clk_i, off during reset
`define GVNE_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("gvne assertion failed");

// Next-cycle implication, clocked on clk_i, off during reset
`define GVNE_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("gvne assertion failed");

`endif

### sv/gvne_pkg.sv
// Shared constants and types of the grid vertex normal estimator
package gvne_pkg;

  localparam int MaxColumnsDef = 63;
  localparam int CoordBitsDef  = 18;
  localparam int QueueDepth    = 2;
  localparam int ColW          = 6;
  localparam int SlotW         = 7;
  localparam int VidxW         = 16;
  localparam int NormW         = 16;
  localparam logic [ColW-1:0] ColumnsReset = 6'd4;

  typedef struct packed {
    logic [SlotW-1:0] p_slot;
    logic [SlotW-1:0] u_slot;
    logic [SlotW-1:0] v_slot;
    logic             missing;
    logic             flip;
    logic             last;
  } job_t;

  typedef struct packed {
    logic signed [NormW-1:0] norm_x;
    logic signed [NormW-1:0] norm_y;
    logic signed [NormW-1:0] norm_z;
    logic                    degenerate;
    logic                    run_last;
  } res_t;

  typedef struct packed {
    logic             en;
    logic [SlotW-1:0] slot;
  } wr_ctl_t;

endpackage

### sv/grid_vertex_normal_estimator_unit.sv
// Top level of the grid vertex normal estimator.
// The back part reads the vertices, forms the cross product, takes a bit-serial
// square root of its squared length and divides each component by that root.
// Flushes issue one request a cycle while the job queue has room.
// Reset is asynchronous, active low: empties both queues, columns returns to 4.
module grid_vertex_normal_estimator_unit
  import gvne_pkg::*;
#(
  parameter int MAX_COLUMNS = MaxColumnsDef,
  parameter int COORD_BITS  = CoordBitsDef
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         push,
  output logic                         full,
  input  logic signed [COORD_BITS-1:0] pos_x_i,
  input  logic signed [COORD_BITS-1:0] pos_y_i,
  input  logic signed [COORD_BITS-1:0] pos_z_i,
  input  logic                         grid_end_i,
  output logic                         empty,
  input  logic                         pop,
  output logic signed [NormW-1:0]      norm_x_o,
  output logic signed [NormW-1:0]      norm_y_o,
  output logic signed [NormW-1:0]      norm_z_o,
  output logic                         degenerate_o,
  output logic                         run_last_o,
  input  logic                         cfg_valid_i,
  output logic                         cfg_ready_o,
  input  logic [ColW-1:0]              cfg_columns_i
);

  job_t                    job_in, job_out;
  logic                    job_push, job_pop, job_full, job_empty;
  wr_ctl_t                 wr;
  logic [3*COORD_BITS-1:0] wr_data;
  res_t                    res_in, res_out;
  logic                    res_push, res_full;

  assign cfg_ready_o = 1'b1;

  gvne_front #(.MAX_COLUMNS(MAX_COLUMNS), .COORD_BITS(COORD_BITS)) u_front (
    .clk_i, .rst_ni,
    .push_i(push), .full_o(full),
    .pos_x_i, .pos_y_i, .pos_z_i, .grid_end_i,
    .cfg_valid_i, .cfg_columns_i,
    .job_push_o(job_push), .job_o(job_in),
    .job_full_i(job_full), .job_empty_i(job_empty),
    .wr_o(wr), .wr_data_o(wr_data)
  );

  gvne_fifo #(.W($bits(job_t)), .DEPTH(QueueDepth)) u_job_q (
    .clk_i, .rst_ni,
    .push_i(job_push), .data_i(job_in), .full_o(job_full),
    .pop_i(job_pop), .data_o(job_out), .empty_o(job_empty)
  );

  gvne_back #(.MAX_COLUMNS(MAX_COLUMNS), .COORD_BITS(COORD_BITS)) u_back (
    .clk_i, .rst_ni,
    .wr_i(wr), .wr_data_i(wr_data),
    .job_i(job_out), .job_empty_i(job_empty), .job_pop_o(job_pop),
    .res_o(res_in), .res_push_o(res_push), .res_full_i(res_full)
  );

  gvne_fifo #(.W($bits(res_t)), .DEPTH(QueueDepth)) u_res_q (
    .clk_i, .rst_ni,
    .push_i(res_push), .data_i(res_in), .full_o(res_full),
    .pop_i(pop), .data_o(res_out), .empty_o(empty)
  );

  assign norm_x_o     = res_out.norm_x;
  assign norm_y_o     = res_out.norm_y;
  assign norm_z_o     = res_out.norm_z;
  assign degenerate_o = res_out.degenerate;
  assign run_last_o   = res_out.run_last;

endmodule

### sv/gvne_fifo.sv
// Small synchronous queue used between the parts of the estimator
module gvne_fifo
  import gvne_pkg::*;
#(
  parameter int W     = 8,
  parameter int DEPTH = QueueDepth
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         push_i,
  input  logic [W-1:0] data_i,
  output logic         full_o,
  input  logic         pop_i,
  output logic [W-1:0] data_o,
  output logic         empty_o
);

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  logic [W-1:0]  mem_q [DEPTH];
  logic [PW-1:0] wr_q, rd_q;
  logic [CW-1:0] cnt_q;
  logic          do_push, do_pop;

  assign full_o  = (cnt_q == CW'(DEPTH));
  assign empty_o = (cnt_q == '0);
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;
  assign data_o  = mem_q[rd_q];

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_q] <= data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (do_push) begin
        wr_q <= (wr_q == PW'(DEPTH - 1)) ? '0 : wr_q + 1'b1;
      end
      if (do_pop) begin
        rd_q <= (rd_q == PW'(DEPTH - 1)) ? '0 : rd_q + 1'b1;
      end
      if (do_push && !do_pop) begin
        cnt_q <= cnt_q + 1'b1;
      end else if (do_pop && !do_push) begin
        cnt_q <= cnt_q - 1'b1;
      end
    end
  end

endmodule

### sv/gvne_front.sv
// Front part: accepts vertices, tracks grid position, issues normal requests
module gvne_front
  import gvne_pkg::*;
#(
  parameter int MAX_COLUMNS = MaxColumnsDef,
  parameter int COORD_BITS  = CoordBitsDef
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         push_i,
  output logic                         full_o,
  input  logic signed [COORD_BITS-1:0] pos_x_i,
  input  logic signed [COORD_BITS-1:0] pos_y_i,
  input  logic signed [COORD_BITS-1:0] pos_z_i,
  input  logic                         grid_end_i,
  input  logic                         cfg_valid_i,
  input  logic [ColW-1:0]              cfg_columns_i,
  output logic                         job_push_o,
  output job_t                         job_o,
  input  logic                         job_full_i,
  input  logic                         job_empty_i,
  output wr_ctl_t                      wr_o,
  output logic [3*COORD_BITS-1:0]      wr_data_o
);

  localparam int WIN = 2 * MAX_COLUMNS + 2;
  localparam int AW  = $clog2(WIN);

  typedef enum logic {F_IDLE, F_GEN} fstate_e;

  fstate_e          state_q;
  logic [ColW-1:0]  columns_q, colpos_q, c_q, col_q, j_q;
  logic [VidxW-1:0] vidx_q, k_q;
  logic [AW-1:0]    ring_q, s_q;
  logic             end_q, main_q;

  logic [ColW-1:0]  c_eff, colj, cnt_fl;
  logic [ColW:0]    d, ud, vd, colsum;
  logic             row0, acc, main_acc;
  logic [VidxW:0]   vinc;

  function automatic logic [AW-1:0] back_slot(logic [AW-1:0] s, logic [ColW:0] dd);
    logic [AW:0] t;
    t = {1'b0, s} + (AW+1)'(WIN) - (AW+1)'(dd);
    if (t >= (AW+1)'(WIN)) begin
      t = t - (AW+1)'(WIN);
    end
    return t[AW-1:0];
  endfunction

  always_comb begin
    c_eff = columns_q;
    if (columns_q < ColW'(2)) begin
      c_eff = ColW'(2);
    end else if (columns_q > ColW'(MAX_COLUMNS)) begin
      c_eff = ColW'(MAX_COLUMNS);
    end
  end

  assign full_o   = (state_q != F_IDLE) || !job_empty_i;
  assign acc      = push_i && !full_o;
  assign vinc     = {1'b0, vidx_q} + 1'b1;
  assign main_acc = (vidx_q >= VidxW'(c_eff));
  assign cnt_fl   = (vinc < (VidxW+1)'(c_eff)) ? vinc[ColW-1:0] : c_eff;

  always_comb begin
    d      = main_q ? {1'b0, c_q} : {1'b0, j_q};
    colsum = {1'b0, col_q} + {1'b0, c_q} - {1'b0, j_q};
    if (main_q) begin
      colj = col_q;
      row0 = (k_q < VidxW'({c_q, 1'b0}));
    end else begin
      colj = (colsum >= {1'b0, c_q}) ? colsum[ColW-1:0] - c_q : colsum[ColW-1:0];
      row0 = ({1'b0, k_q} < (VidxW+1)'({1'b0, c_q} + {1'b0, j_q}));
    end
    ud = (colj != '0) ? d + 1'b1 : d - 1'b1;
    vd = row0 ? d - {1'b0, c_q} : d + {1'b0, c_q};
    job_o.p_slot  = SlotW'(back_slot(s_q, d));
    job_o.u_slot  = SlotW'(back_slot(s_q, ud));
    job_o.v_slot  = SlotW'(back_slot(s_q, vd));
    job_o.missing = ((colj == '0) && (d == '0)) || (row0 && (d < {1'b0, c_q}));
    job_o.flip    = (colj == '0) || row0;
    job_o.last    = !main_q && (j_q == '0);
  end

  assign job_push_o = (state_q == F_GEN) && !job_full_i;
  assign wr_o.en    = acc;
  assign wr_o.slot  = SlotW'(ring_q);
  assign wr_data_o  = {pos_x_i, pos_y_i, pos_z_i};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= F_IDLE;
      columns_q <= ColumnsReset;
      colpos_q  <= '0;
      vidx_q    <= '0;
      ring_q    <= '0;
      main_q    <= 1'b0;
      end_q     <= 1'b0;
      c_q       <= '0;
      col_q     <= '0;
      j_q       <= '0;
      k_q       <= '0;
      s_q       <= '0;
    end else begin
      if (cfg_valid_i) begin
        columns_q <= cfg_columns_i;
        colpos_q  <= '0;
        vidx_q    <= '0;
      end
      case (state_q)
        F_IDLE: begin
          if (acc) begin
            k_q    <= vidx_q;
            c_q    <= c_eff;
            col_q  <= colpos_q;
            s_q    <= ring_q;
            end_q  <= grid_end_i;
            main_q <= main_acc;
            j_q    <= cnt_fl - 1'b1;
            ring_q <= (ring_q == AW'(WIN - 1)) ? '0 : ring_q + 1'b1;
            if (grid_end_i) begin
              vidx_q   <= '0;
              colpos_q <= '0;
            end else begin
              if (vidx_q != '1) begin
                vidx_q <= vinc[VidxW-1:0];
              end
              colpos_q <= (colpos_q + 1'b1 == c_eff) ? '0 : colpos_q + 1'b1;
            end
            if (main_acc || grid_end_i) begin
              state_q <= F_GEN;
            end
          end
        end
        F_GEN: begin
          if (!job_full_i) begin
            if (main_q) begin
              main_q <= 1'b0;
              if (!end_q) begin
                state_q <= F_IDLE;
              end
            end else if (j_q == '0) begin
              state_q <= F_IDLE;
            end else begin
              j_q <= j_q - 1'b1;
            end
          end
        end
        default: state_q <= F_IDLE;
      endcase
    end
  end

endmodule

### sv/gvne_back.sv
// Back part: vertex window memory, cross product, square root and divide
`include "grid_vertex_normal_estimator_unit_macros.svh"
module gvne_back
  import gvne_pkg::*;
#(
  parameter int MAX_COLUMNS = MaxColumnsDef,
  parameter int COORD_BITS  = CoordBitsDef
) (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  wr_ctl_t                 wr_i,
  input  logic [3*COORD_BITS-1:0] wr_data_i,
  input  job_t                    job_i,
  input  logic                    job_empty_i,
  output logic                    job_pop_o,
  output res_t                    res_o,
  output logic                    res_push_o,
  input  logic                    res_full_i
);

  localparam int WIN = 2 * MAX_COLUMNS + 2;
  localparam int AW  = $clog2(WIN);
  localparam int CB  = COORD_BITS;
  localparam int DW  = CB + 1;
  localparam int MW  = (DW > 16) ? DW : 16;

  typedef enum logic [3:0] {
    B_IDLE, B_RD1, B_RD2, B_SHRINK, B_CROSS, B_SQUARE, B_SQRT, B_DIV, B_PUSH
  } bstate_e;

  logic [3*CB-1:0] mem_q [WIN];
  logic [3*CB-1:0] rda_q, rdb_q, p_q;
  logic [AW-1:0]   ra, rb;

  bstate_e                 state_q;
  job_t                    job_q;
  logic [5:0]              cnt_q;
  logic [5:0]              cm1;
  logic [1:0]              cidx;
  logic [1:0]              comp_q;
  logic signed [DW-1:0]    a_q [3];
  logic signed [DW-1:0]    b_q [3];
  logic signed [DW-1:0]    a_d [3];
  logic signed [DW-1:0]    b_d [3];
  logic signed [15:0]      as_q [3];
  logic signed [15:0]      bs_q [3];
  logic signed [32:0]      c_q [3];
  logic signed [NormW-1:0] norm_q [3];
  logic                    deg_q;
  logic signed [65:0]      prod_q, prod_d;
  logic signed [32:0]      ma, mb, magc;
  logic [63:0]             s_q, s_fin;
  logic [31:0]             root_q, divrem_q;
  logic [33:0]             rem_q;
  logic [35:0]             rem2, trial;
  logic [14:0]             low_q, q_q, q_next;
  logic [32:0]             r2;
  logic [46:0]             num;
  logic [4:0]              sha, shb;
  logic                    neg;

  function automatic logic signed [CB-1:0] coord(logic [3*CB-1:0] w, int i);
    return w[(2-i)*CB +: CB];
  endfunction

  function automatic logic [MW-1:0] vmag(logic signed [DW-1:0] v);
    logic [DW-1:0] m;
    m = v[DW-1] ? DW'(-v) : DW'(v);
    return MW'(m);
  endfunction

  function automatic logic [4:0] shamt(logic [MW-1:0] o);
    logic [4:0] sh;
    sh = '0;
    for (int i = 15; i < MW; i++) begin
      if (o[i]) begin
        sh = 5'(i - 14);
      end
    end
    return sh;
  endfunction

  function automatic logic signed [15:0] shr(logic signed [DW-1:0] v, logic [4:0] sh);
    logic [MW-1:0] t;
    logic [15:0]   r;
    t = vmag(v) >> sh;
    r = {1'b0, t[14:0]};
    return v[DW-1] ? -r : r;
  endfunction

  assign job_pop_o = (state_q == B_IDLE) && !job_empty_i;
  assign ra = (state_q == B_RD1) ? job_q.v_slot[AW-1:0] : job_i.p_slot[AW-1:0];
  assign rb = job_i.u_slot[AW-1:0];
  assign cm1  = cnt_q - 6'd1;
  assign cidx = cm1[2:1];

  always_ff @(posedge clk_i) begin
    if (wr_i.en) begin
      mem_q[wr_i.slot[AW-1:0]] <= wr_data_i;
    end
    rda_q <= mem_q[ra];
    rdb_q <= mem_q[rb];
  end

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      a_d[i] = DW'(coord(rda_q, i)) - DW'(coord(rdb_q, i));
      b_d[i] = DW'(coord(rda_q, i)) - DW'(coord(p_q, i));
    end
    sha = shamt(vmag(a_q[0]) | vmag(a_q[1]) | vmag(a_q[2]));
    shb = shamt(vmag(b_q[0]) | vmag(b_q[1]) | vmag(b_q[2]));
  end

  always_comb begin
    ma   = '0;
    mb   = '0;
    magc = c_q[cnt_q[1:0] == 2'd3 ? 2'd0 : cnt_q[1:0]];
    if (state_q == B_DIV) begin
      magc = c_q[comp_q == 2'd3 ? 2'd0 : comp_q];
    end
    if (magc[32]) begin
      magc = -magc;
    end
    if (state_q == B_CROSS) begin
      case (cnt_q)
        6'd0: begin ma = 33'(as_q[1]); mb = 33'(bs_q[2]); end
        6'd1: begin ma = 33'(as_q[2]); mb = 33'(bs_q[1]); end
        6'd2: begin ma = 33'(as_q[2]); mb = 33'(bs_q[0]); end
        6'd3: begin ma = 33'(as_q[0]); mb = 33'(bs_q[2]); end
        6'd4: begin ma = 33'(as_q[0]); mb = 33'(bs_q[1]); end
        6'd5: begin ma = 33'(as_q[1]); mb = 33'(bs_q[0]); end
        default: begin ma = '0; mb = '0; end
      endcase
    end else if (state_q == B_SQUARE) begin
      ma = magc;
      mb = magc;
    end
    prod_d = ma * mb;
    s_fin  = s_q + prod_q[63:0];
    rem2   = {rem_q, s_q[63:62]};
    trial  = {2'b00, root_q, 2'b01};
    num    = {1'b0, magc[31:0], 14'b0} + 47'(root_q >> 1);
    r2     = {divrem_q, low_q[14]};
    q_next = {q_q[13:0], (r2 >= {1'b0, root_q})};
    neg    = magc != c_q[comp_q == 2'd3 ? 2'd0 : comp_q];
    neg    = neg ^ job_q.flip;
  end

  assign res_push_o      = (state_q == B_PUSH) && !res_full_i;
  assign res_o.norm_x     = norm_q[0];
  assign res_o.norm_y     = norm_q[1];
  assign res_o.norm_z     = norm_q[2];
  assign res_o.degenerate = deg_q;
  assign res_o.run_last   = job_q.last;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= B_IDLE;
      cnt_q   <= '0;
      comp_q  <= '0;
    end else begin
      prod_q <= prod_d;
      case (state_q)
        B_IDLE: begin
          if (!job_empty_i) begin
            job_q <= job_i;
            if (job_i.missing) begin
              for (int i = 0; i < 3; i++) begin
                norm_q[i] <= '0;
              end
              deg_q   <= 1'b1;
              state_q <= B_PUSH;
            end else begin
              state_q <= B_RD1;
            end
          end
        end
        B_RD1: begin
          p_q <= rda_q;
          a_q <= a_d;
          state_q <= B_RD2;
        end
        B_RD2: begin
          b_q <= b_d;
          state_q <= B_SHRINK;
        end
        B_SHRINK: begin
          for (int i = 0; i < 3; i++) begin
            as_q[i] <= shr(a_q[i], sha);
            bs_q[i] <= shr(b_q[i], shb);
          end
          cnt_q   <= '0;
          state_q <= B_CROSS;
        end
        B_CROSS: begin
          if (cnt_q != '0) begin
            if (cnt_q[0]) begin
              c_q[cidx] <= prod_q[32:0];
            end else begin
              c_q[cidx] <= c_q[cidx] - prod_q[32:0];
            end
          end
          if (cnt_q == 6'd6) begin
            cnt_q   <= '0;
            state_q <= B_SQUARE;
          end else begin
            cnt_q <= cnt_q + 1'b1;
          end
        end
        B_SQUARE: begin
          if (cnt_q == 6'd1) begin
            s_q <= prod_q[63:0];
          end else if (cnt_q != '0) begin
            s_q <= s_fin;
          end
          if (cnt_q == 6'd3) begin
            cnt_q  <= '0;
            root_q <= '0;
            rem_q  <= '0;
            if (s_fin == '0) begin
              for (int i = 0; i < 3; i++) begin
                norm_q[i] <= '0;
              end
              deg_q   <= 1'b1;
              state_q <= B_PUSH;
            end else begin
              state_q <= B_SQRT;
            end
          end else begin
            cnt_q <= cnt_q + 1'b1;
          end
        end
        B_SQRT: begin
          if (rem2 >= trial) begin
            rem_q  <= 34'(rem2 - trial);
            root_q <= {root_q[30:0], 1'b1};
          end else begin
            rem_q  <= rem2[33:0];
            root_q <= {root_q[30:0], 1'b0};
          end
          s_q <= {s_q[61:0], 2'b00};
          if (cnt_q == 6'd31) begin
            cnt_q   <= '0;
            comp_q  <= '0;
            state_q <= B_DIV;
          end else begin
            cnt_q <= cnt_q + 1'b1;
          end
        end
        B_DIV: begin
          if (cnt_q == '0) begin
            divrem_q <= num[46:15];
            low_q    <= num[14:0];
            q_q      <= '0;
            cnt_q    <= cnt_q + 1'b1;
          end else begin
            if (r2 >= {1'b0, root_q}) begin
              divrem_q <= 32'(r2 - {1'b0, root_q});
            end else begin
              divrem_q <= r2[31:0];
            end
            low_q <= {low_q[13:0], 1'b0};
            q_q   <= q_next;
            if (cnt_q == 6'd15) begin
              norm_q[comp_q == 2'd3 ? 2'd0 : comp_q] <=
                neg ? -{1'b0, q_next} : {1'b0, q_next};
              cnt_q <= '0;
              if (comp_q == 2'd2) begin
                deg_q   <= 1'b0;
                state_q <= B_PUSH;
              end else begin
                comp_q <= comp_q + 1'b1;
              end
            end else begin
              cnt_q <= cnt_q + 1'b1;
            end
          end
        end
        B_PUSH: begin
          if (!res_full_i) begin
            state_q <= B_IDLE;
          end
        end
        default: state_q <= B_IDLE;
      endcase
    end
  end

  `GVNE_ASSERT_IMP(a_deg_zero, res_push_o && res_o.degenerate, res_o.norm_x == '0 && res_o.norm_y == '0 && res_o.norm_z == '0)
  `GVNE_ASSERT_IMP(a_sqrt_nonzero, state_q == B_SQRT && cnt_q == '0, s_q != '0)
  `GVNE_ASSERT_IMP(a_div_len, state_q == B_DIV && cnt_q != '0, root_q != '0)
  `GVNE_ASSERT_NEXT(a_pop_busy, job_pop_o, state_q != B_IDLE)

endmodule
